// ===== rtl/text_console_frame_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text console frame writer assertion macros
// shared property forms for the console checks, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_FRAME_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_FRAME_WRITER_ASSERT_SVH

// same-cycle implication
`define TCFW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("console check failed: same-cycle implication");

// next-cycle implication
`define TCFW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("console check failed: next-cycle implication");

`endif

// ===== rtl/tcfw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfw_pkg
// geometry, codes and shared types of the text console frame writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcfw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_ROW   = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);

  // port field widths
  localparam int ACTION_W = 3;
  localparam int CHAR_W   = 8;
  localparam int NUM_W    = 16;
  localparam int CADDR_W  = 11;
  localparam int CUR_W    = 11;
  localparam int CELL_W   = 16;

  // decimal split: x / 10 == (x * 0xCCCD) >> 19 for any 16-bit x
  localparam int            DIGITS      = 5;
  localparam int            DIG_IDX_W   = 3;
  localparam logic [15:0]   DIV10_MUL   = 16'hCCCD;
  localparam int            DIV10_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;

  // cell contents
  localparam logic [7:0]        BLANK_ATTR   = 8'h07;
  localparam logic [7:0]        SPACE_CHAR   = 8'h20;
  localparam logic [7:0]        NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0]        DIGIT_ZERO   = 8'h30;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, SPACE_CHAR};

  // action codes on the input channel
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT_CHAR = 3'd0,
    ACT_PUT_DEC  = 3'd1,
    ACT_DELETE   = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_PAINT    = 3'd4,
    ACT_READ     = 3'd5
  } act_t;

  // internal operation after classification
  typedef enum logic [2:0] {
    OP_CHAR,
    OP_DEC,
    OP_DEL,
    OP_CLEAR,
    OP_PAINT,
    OP_READ,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SPLIT,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_INIT,
    BS_IDLE,
    BS_DIGIT,
    BS_COPY,
    BS_BLANK,
    BS_FILL,
    BS_RESP
  } back_state_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t                          op;
    logic [CHAR_W-1:0]            char_code;
    logic [7:0]                   color;
    logic [DIGITS-1:0][3:0]       digits;
    logic [DIG_IDX_W-1:0]         ndig;
    logic [ADDR_W-1:0]            addr;
    logic                         addr_ok;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/tcfw_channels.sv =====
// ----------------------------------------------------------------------------
// tcfw channels
// valid/ready channel bundles for console items and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcfw_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcfw_pkg::ACTION_W-1:0]  action;
  logic [tcfw_pkg::CHAR_W-1:0]    char_code;
  logic [7:0]                     color;
  logic [tcfw_pkg::NUM_W-1:0]     number;
  logic [tcfw_pkg::CADDR_W-1:0]   cell_address;

  modport source (output valid, action, char_code, color, number, cell_address,
                  input ready);
  modport sink   (input valid, action, char_code, color, number, cell_address,
                  output ready);
endinterface

interface tcfw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcfw_pkg::CUR_W-1:0]   cursor_position;
  logic [tcfw_pkg::CELL_W-1:0]  cell_data;
  logic                         scrolled;

  modport source (output valid, cursor_position, cell_data, scrolled, input ready);
  modport sink   (input valid, cursor_position, cell_data, scrolled, output ready);
endinterface

// ===== rtl/text_console_frame_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_frame_writer
// text-mode console: cell store, cursor, character and decimal output
// ----------------------------------------------------------------------------
// After reset the block blanks all CELL_COUNT cells (2000) of the cell store
// before it takes its first item. Every item gives one result. A put
// char, delete, read cell or unused action makes one store access in the
// back end and then gives its result; put decimal writes its digits one by one
// in the back end, after the front end has split the number at one digit per
// cycle, which overlaps earlier work through the two-entry command queue. Clear
// and paint sweep every cell before the result, and each scroll copies the
// rows up and blanks the last row one cell at a time, since every cell moves
// through the single write port of the cell store.
`timescale 1ns / 1ps
`include "text_console_frame_writer_assert.svh"

module text_console_frame_writer (
  input  logic        clk,
  input  logic        rst_n,
  tcfw_in_if.sink     in_item,
  tcfw_out_if.source  out_item
);

  tcfw_pkg::q_stat_t               q_stat;
  tcfw_pkg::cmd_t                  push_cmd;
  tcfw_pkg::cmd_t                  head;
  tcfw_pkg::ram_req_t              ram_req;
  logic                            push;
  logic                            pop;
  logic                            init_done;
  logic [tcfw_pkg::CELL_W-1:0]     ram_rdata;

  // accept and classify
  tcfw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .init_done (init_done),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // command queue
  tcfw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // execution
  tcfw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .init_done (init_done),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_item  (out_item)
  );

  // cell store
  tcfw_ram #(
    .WIDTH (tcfw_pkg::CELL_W),
    .DEPTH (tcfw_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // checks
  `TCFW_ASSERT_IMPL(a_accept_after_init, in_item.valid && in_item.ready, init_done)
  `TCFW_ASSERT_IMPL(a_no_pop_empty, pop, !q_stat.empty)
  `TCFW_ASSERT_IMPL(a_no_push_full, push, !q_stat.full)
  `TCFW_ASSERT_IMPL(a_write_in_range, ram_req.we, 32'(ram_req.waddr) < 32'(tcfw_pkg::CELL_COUNT))
  `TCFW_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty)

endmodule

// ===== rtl/tcfw_ram.sv =====
// ----------------------------------------------------------------------------
// tcfw_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tcfw_front.sv =====
// ----------------------------------------------------------------------------
// tcfw_front
// accepts items, classifies the action and splits numbers into decimal digits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcfw_front (
  input  logic              clk,
  input  logic              rst_n,
  tcfw_in_if.sink           in_item,
  input  logic              init_done,
  input  tcfw_pkg::q_stat_t q_stat,
  output logic              push,
  output tcfw_pkg::cmd_t    push_cmd
);

  tcfw_pkg::front_state_t                state_r, state_nxt;
  tcfw_pkg::cmd_t                        cmd_r, cmd_nxt;
  logic [tcfw_pkg::NUM_W-1:0]            num_r, num_nxt;
  logic [tcfw_pkg::DIG_IDX_W-1:0]        cnt_r, cnt_nxt;

  logic [31:0]                           prod;
  logic [tcfw_pkg::NUM_W-1:0]            quot;
  logic [tcfw_pkg::NUM_W-1:0]            rem;
  logic [tcfw_pkg::ADDR_W+tcfw_pkg::CADDR_W-1:0] addr_ext;

  // one decimal digit per cycle: quotient by reciprocal, remainder by shift-subtract
  assign prod = {16'b0, num_r} * {16'b0, tcfw_pkg::DIV10_MUL};
  assign quot = tcfw_pkg::NUM_W'(prod >> tcfw_pkg::DIV10_SHIFT);
  assign rem  = num_r - (quot << 3) - (quot << 1);

  assign addr_ext = {{tcfw_pkg::ADDR_W{1'b0}}, in_item.cell_address};

  assign push_cmd = cmd_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcfw_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    num_r <= num_nxt;
    cnt_r <= cnt_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    num_nxt       = num_r;
    cnt_nxt       = cnt_r;
    push          = 1'b0;
    in_item.ready = (state_r == tcfw_pkg::FS_IDLE) && init_done;

    case (state_r)
      tcfw_pkg::FS_IDLE: begin
        if (in_item.valid && in_item.ready) begin
          cmd_nxt.char_code = in_item.char_code;
          cmd_nxt.color     = in_item.color;
          cmd_nxt.digits    = '0;
          cmd_nxt.ndig      = '0;
          cmd_nxt.addr      = addr_ext[tcfw_pkg::ADDR_W-1:0];
          cmd_nxt.addr_ok   = (32'(in_item.cell_address) < 32'(tcfw_pkg::CELL_COUNT));
          num_nxt           = in_item.number;
          cnt_nxt           = '0;
          state_nxt         = tcfw_pkg::FS_PUSH;
          case (in_item.action)
            tcfw_pkg::ACT_PUT_CHAR: cmd_nxt.op = tcfw_pkg::OP_CHAR;
            tcfw_pkg::ACT_PUT_DEC: begin
              cmd_nxt.op = tcfw_pkg::OP_DEC;
              state_nxt  = tcfw_pkg::FS_SPLIT;
            end
            tcfw_pkg::ACT_DELETE:   cmd_nxt.op = tcfw_pkg::OP_DEL;
            tcfw_pkg::ACT_CLEAR:    cmd_nxt.op = tcfw_pkg::OP_CLEAR;
            tcfw_pkg::ACT_PAINT:    cmd_nxt.op = tcfw_pkg::OP_PAINT;
            tcfw_pkg::ACT_READ:     cmd_nxt.op = tcfw_pkg::OP_READ;
            default:                cmd_nxt.op = tcfw_pkg::OP_NOP;
          endcase
        end
      end

      // digits are stored least significant first
      tcfw_pkg::FS_SPLIT: begin
        cmd_nxt.digits[cnt_r] = rem[3:0];
        num_nxt               = quot;
        cnt_nxt               = cnt_r + 1'b1;
        if (quot == '0 || cnt_r == tcfw_pkg::DIG_IDX_W'(tcfw_pkg::DIGITS - 1)) begin
          cmd_nxt.ndig = cnt_r + 1'b1;
          state_nxt    = tcfw_pkg::FS_PUSH;
        end
      end

      tcfw_pkg::FS_PUSH: begin
        if (!q_stat.full) begin
          push      = 1'b1;
          state_nxt = tcfw_pkg::FS_IDLE;
        end
      end

      default: state_nxt = tcfw_pkg::FS_IDLE;
    endcase
  end

endmodule

// ===== rtl/tcfw_queue.sv =====
// ----------------------------------------------------------------------------
// tcfw_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcfw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcfw_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output tcfw_pkg::cmd_t    head,
  output tcfw_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (tcfw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcfw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcfw_pkg::QUEUE_DEPTH + 1);

  tcfw_pkg::cmd_t     mem_r [tcfw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign head         = mem_r[rp_r];
  assign q_stat.full  = (count_r == CNT_W'(tcfw_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  // pointer and count update
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(tcfw_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(tcfw_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/tcfw_back.sv =====
// ----------------------------------------------------------------------------
// tcfw_back
// executes commands on the cell store: writes, scrolls, fills and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcfw_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcfw_pkg::cmd_t               head,
  input  tcfw_pkg::q_stat_t            q_stat,
  output logic                         pop,
  output logic                         init_done,
  output tcfw_pkg::ram_req_t           ram_req,
  input  logic [tcfw_pkg::CELL_W-1:0]  ram_rdata,
  tcfw_out_if.source                   out_item
);

  localparam int AW = tcfw_pkg::ADDR_W;
  localparam int CW = tcfw_pkg::COL_W;

  tcfw_pkg::back_state_t          state_r, state_nxt;
  logic [AW-1:0]                  cursor_r, cursor_nxt;
  logic [CW-1:0]                  col_r, col_nxt;
  logic [AW-1:0]                  cnt_r, cnt_nxt;
  logic [tcfw_pkg::DIG_IDX_W-1:0] dig_r, dig_nxt;
  logic                           scrolled_r, scrolled_nxt;
  logic                           more_r, more_nxt;
  logic                           use_ram_r, use_ram_nxt;
  logic [tcfw_pkg::CELL_W-1:0]    fill_val_r, fill_val_nxt;
  logic [tcfw_pkg::CELL_W-1:0]    force_r, force_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [tcfw_pkg::CUR_W-1:0]     out_cursor_r, out_cursor_nxt;
  logic [tcfw_pkg::CELL_W-1:0]    out_cell_r, out_cell_nxt;
  logic                           out_scr_r, out_scr_nxt;

  // one character step
  logic [tcfw_pkg::CHAR_W-1:0]    step_ch;
  logic [AW:0]                    step_cur;
  logic [CW-1:0]                  step_col;
  logic                           step_we;
  logic                           step_wrap;
  logic                           step_last;
  logic                           step_go;
  logic [AW-1:0]                  del_cur;
  logic [AW+tcfw_pkg::CUR_W-1:0]  cur_ext;

  assign init_done = (state_r != tcfw_pkg::BS_INIT);

  assign out_item.valid           = out_valid_r;
  assign out_item.cursor_position = out_cursor_r;
  assign out_item.cell_data       = out_cell_r;
  assign out_item.scrolled        = out_scr_r;

  assign cur_ext = {{tcfw_pkg::CUR_W{1'b0}}, cursor_r};
  assign del_cur = (cursor_r == '0) ? '0 : cursor_r - 1'b1;

  // cursor advance for a character or a newline
  always_comb begin
    if (state_r == tcfw_pkg::BS_DIGIT) begin
      step_ch = tcfw_pkg::DIGIT_ZERO + {4'b0000, head.digits[dig_r]};
    end else begin
      step_ch = head.char_code;
    end
    step_last = (state_r != tcfw_pkg::BS_DIGIT) || (dig_r == '0);
    if (step_ch == tcfw_pkg::NEWLINE_CHAR) begin
      step_cur = {1'b0, cursor_r} - (AW+1)'(col_r) + (AW+1)'(tcfw_pkg::COLUMNS);
      step_col = '0;
      step_we  = 1'b0;
    end else begin
      step_cur = {1'b0, cursor_r} + 1'b1;
      step_col = (col_r == CW'(tcfw_pkg::COLUMNS - 1)) ? '0 : col_r + 1'b1;
      step_we  = 1'b1;
    end
    step_wrap = (step_cur >= (AW+1)'(tcfw_pkg::CELL_COUNT));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcfw_pkg::BS_INIT;
      cursor_r    <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dig_r        <= dig_nxt;
    scrolled_r   <= scrolled_nxt;
    more_r       <= more_nxt;
    use_ram_r    <= use_ram_nxt;
    fill_val_r   <= fill_val_nxt;
    force_r      <= force_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_cell_r   <= out_cell_nxt;
    out_scr_r    <= out_scr_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    col_nxt        = col_r;
    cnt_nxt        = cnt_r;
    dig_nxt        = dig_r;
    scrolled_nxt   = scrolled_r;
    more_nxt       = more_r;
    use_ram_nxt    = use_ram_r;
    fill_val_nxt   = fill_val_r;
    force_nxt      = force_r;
    out_valid_nxt  = out_valid_r && !out_item.ready;
    out_cursor_nxt = out_cursor_r;
    out_cell_nxt   = out_cell_r;
    out_scr_nxt    = out_scr_r;
    pop            = 1'b0;
    step_go        = 1'b0;
    ram_req        = '0;

    case (state_r)
      // clearing pass over the store after reset
      tcfw_pkg::BS_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r;
        ram_req.wdata = tcfw_pkg::BLANK_CELL;
        if (cnt_r == AW'(tcfw_pkg::CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tcfw_pkg::BS_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcfw_pkg::BS_IDLE: begin
        if (!q_stat.empty) begin
          scrolled_nxt = 1'b0;
          case (head.op)
            tcfw_pkg::OP_CHAR: step_go = 1'b1;
            tcfw_pkg::OP_DEC: begin
              dig_nxt   = head.ndig - 1'b1;
              state_nxt = tcfw_pkg::BS_DIGIT;
            end
            tcfw_pkg::OP_DEL: begin
              cursor_nxt = del_cur;
              if (cursor_r != '0) begin
                col_nxt = (col_r == '0) ? CW'(tcfw_pkg::COLUMNS - 1) : col_r - 1'b1;
              end
              ram_req.we    = 1'b1;
              ram_req.waddr = del_cur;
              ram_req.wdata = tcfw_pkg::BLANK_CELL;
              force_nxt     = tcfw_pkg::BLANK_CELL;
              use_ram_nxt   = 1'b0;
              state_nxt     = tcfw_pkg::BS_RESP;
            end
            tcfw_pkg::OP_CLEAR, tcfw_pkg::OP_PAINT: begin
              fill_val_nxt = (head.op == tcfw_pkg::OP_PAINT) ?
                             {head.color, tcfw_pkg::SPACE_CHAR} : tcfw_pkg::BLANK_CELL;
              cnt_nxt      = '0;
              cursor_nxt   = '0;
              col_nxt      = '0;
              state_nxt    = tcfw_pkg::BS_FILL;
            end
            tcfw_pkg::OP_READ: begin
              ram_req.re    = head.addr_ok;
              ram_req.raddr = head.addr;
              use_ram_nxt   = head.addr_ok;
              force_nxt     = '0;
              state_nxt     = tcfw_pkg::BS_RESP;
            end
            default: begin
              ram_req.re    = 1'b1;
              ram_req.raddr = cursor_r;
              use_ram_nxt   = 1'b1;
              state_nxt     = tcfw_pkg::BS_RESP;
            end
          endcase
        end
      end

      tcfw_pkg::BS_DIGIT: step_go = 1'b1;

      // move rows up: read one row below, write the previous cell
      tcfw_pkg::BS_COPY: begin
        if (cnt_r < AW'(tcfw_pkg::LAST_ROW)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cnt_r + AW'(tcfw_pkg::COLUMNS);
        end
        if (cnt_r != '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = cnt_r - 1'b1;
          ram_req.wdata = ram_rdata;
        end
        if (cnt_r == AW'(tcfw_pkg::LAST_ROW)) begin
          state_nxt = tcfw_pkg::BS_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // blank the last row
      tcfw_pkg::BS_BLANK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r;
        ram_req.wdata = tcfw_pkg::BLANK_CELL;
        if (cnt_r == AW'(tcfw_pkg::CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = more_r ? tcfw_pkg::BS_DIGIT : tcfw_pkg::BS_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // clear or paint sweep
      tcfw_pkg::BS_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r;
        ram_req.wdata = fill_val_r;
        if (cnt_r == AW'(tcfw_pkg::CELL_COUNT - 1)) begin
          cnt_nxt     = '0;
          force_nxt   = fill_val_r;
          use_ram_nxt = 1'b0;
          state_nxt   = tcfw_pkg::BS_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // hand the result to the output register
      tcfw_pkg::BS_RESP: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt  = 1'b1;
          out_cursor_nxt = cur_ext[tcfw_pkg::CUR_W-1:0];
          out_cell_nxt   = use_ram_r ? ram_rdata : force_r;
          out_scr_nxt    = scrolled_r;
          pop            = 1'b1;
          state_nxt      = tcfw_pkg::BS_IDLE;
        end
      end

      default: state_nxt = tcfw_pkg::BS_IDLE;
    endcase

    // character step: write the cell unless newline, read the next one, scroll on overflow
    if (step_go) begin
      ram_req.we    = step_we;
      ram_req.waddr = cursor_r;
      ram_req.wdata = {head.color, step_ch};
      if (state_r == tcfw_pkg::BS_DIGIT) begin
        dig_nxt = dig_r - 1'b1;
      end
      if (step_wrap) begin
        cursor_nxt   = AW'(tcfw_pkg::LAST_ROW);
        col_nxt      = '0;
        scrolled_nxt = 1'b1;
        cnt_nxt      = '0;
        more_nxt     = !step_last;
        force_nxt    = tcfw_pkg::BLANK_CELL;
        use_ram_nxt  = 1'b0;
        state_nxt    = tcfw_pkg::BS_COPY;
      end else begin
        cursor_nxt    = step_cur[AW-1:0];
        col_nxt       = step_col;
        ram_req.re    = 1'b1;
        ram_req.raddr = step_cur[AW-1:0];
        use_ram_nxt   = 1'b1;
        state_nxt     = step_last ? tcfw_pkg::BS_RESP : tcfw_pkg::BS_DIGIT;
      end
    end
  end

endmodule

// ===== test/tcfw_console_checker.sv =====
// ----------------------------------------------------------------------------
// tcfw console checker
// watches the item and result channels of the text console, keeps a shadow
// screen and cursor, and compares every result against the predicted view
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcfw_console_checker (
  input  logic        clk,
  input  logic        rst_n,
  tcfw_in_if          in_ch,
  tcfw_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  localparam int REPORT_LIMIT = 10;

  // one predicted result: cursor, reported cell, scroll flag
  typedef struct packed {
    logic [tcfw_pkg::CUR_W-1:0]  cursor_position;
    logic [tcfw_pkg::CELL_W-1:0] cell_data;
    logic                        scrolled;
  } console_view_t;

  logic [tcfw_pkg::CELL_W-1:0] screen_shadow [tcfw_pkg::CELL_COUNT];
  int                          cursor_shadow;
  console_view_t               view_queue [$];

  // set every shadow cell to one value
  function automatic void fill_shadow(logic [tcfw_pkg::CELL_W-1:0] value);
    for (int i = 0; i < tcfw_pkg::CELL_COUNT; i++) screen_shadow[i] = value;
  endfunction

  // write one glyph or newline at the cursor, scroll on overflow
  function automatic bit emit_glyph(logic [tcfw_pkg::CHAR_W-1:0] ch, logic [7:0] attr);
    if (ch == tcfw_pkg::NEWLINE_CHAR) begin
      cursor_shadow += tcfw_pkg::COLUMNS - (cursor_shadow % tcfw_pkg::COLUMNS);
    end else begin
      screen_shadow[cursor_shadow] = {attr, ch};
      cursor_shadow++;
    end
    if (cursor_shadow >= tcfw_pkg::CELL_COUNT) begin
      for (int i = 0; i < tcfw_pkg::LAST_ROW; i++) begin
        screen_shadow[i] = screen_shadow[i + tcfw_pkg::COLUMNS];
      end
      for (int i = tcfw_pkg::LAST_ROW; i < tcfw_pkg::CELL_COUNT; i++) begin
        screen_shadow[i] = tcfw_pkg::BLANK_CELL;
      end
      cursor_shadow = tcfw_pkg::LAST_ROW;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one item to the shadow state and return the view it reports
  function automatic console_view_t step_console(
    logic [tcfw_pkg::ACTION_W-1:0] act,
    logic [tcfw_pkg::CHAR_W-1:0]   ch,
    logic [7:0]                    color,
    logic [tcfw_pkg::NUM_W-1:0]    num,
    logic [tcfw_pkg::CADDR_W-1:0]  addr
  );
    console_view_t view;
    logic [3:0]    digit_stack [tcfw_pkg::DIGITS];
    int            n;
    int unsigned   rest;
    bit            rolled;

    rolled = 1'b0;
    case (act)
      tcfw_pkg::ACT_PUT_CHAR: rolled = emit_glyph(ch, color);
      tcfw_pkg::ACT_PUT_DEC: begin
        // least significant digit first, then printed from the top
        rest = num;
        n    = 0;
        do begin
          digit_stack[n] = 4'(rest % 10);
          rest           = rest / 10;
          n++;
        end while (rest > 0 && n < tcfw_pkg::DIGITS);
        while (n > 0) begin
          n--;
          if (emit_glyph(tcfw_pkg::DIGIT_ZERO + 8'(digit_stack[n]), color)) rolled = 1'b1;
        end
      end
      tcfw_pkg::ACT_DELETE: begin
        if (cursor_shadow > 0) cursor_shadow--;
        screen_shadow[cursor_shadow] = tcfw_pkg::BLANK_CELL;
      end
      tcfw_pkg::ACT_CLEAR: begin
        fill_shadow(tcfw_pkg::BLANK_CELL);
        cursor_shadow = 0;
      end
      tcfw_pkg::ACT_PAINT: begin
        fill_shadow({color, tcfw_pkg::SPACE_CHAR});
        cursor_shadow = 0;
      end
      default: ;
    endcase

    view.cursor_position = tcfw_pkg::CUR_W'(cursor_shadow);
    if (act == tcfw_pkg::ACT_READ) begin
      view.cell_data = (addr < tcfw_pkg::CELL_COUNT) ? screen_shadow[addr] : '0;
    end else begin
      view.cell_data = screen_shadow[cursor_shadow];
    end
    view.scrolled = rolled;
    return view;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // predict on every accepted item, compare on every accepted result
  always @(posedge clk) begin
    console_view_t want;
    if (!rst_n) begin
      fill_shadow(tcfw_pkg::BLANK_CELL);
      cursor_shadow = 0;
      view_queue.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        view_queue.push_back(step_console(in_ch.action, in_ch.char_code, in_ch.color,
                                          in_ch.number, in_ch.cell_address));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (view_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with nothing pending: cursor %0d cell %h scrolled %0b",
                     $realtime, out_ch.cursor_position, out_ch.cell_data, out_ch.scrolled);
        end else begin
          want = view_queue.pop_front();
          if (out_ch.cursor_position !== want.cursor_position ||
              out_ch.cell_data !== want.cell_data ||
              out_ch.scrolled !== want.scrolled) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: mismatch: want cur %0d cell %h scr %0b, got cur %0d cell %h scr %0b",
                       $realtime, want.cursor_position, want.cell_data, want.scrolled,
                       out_ch.cursor_position, out_ch.cell_data, out_ch.scrolled);
          end
        end
      end
    end
    outstanding = view_queue.size();
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives console items in bursts against a stalling receiver: a directed
// opening over field extremes and every action, then a weighted random mix
// that fills, scrolls, paints and reads the screen
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // action codes the block leaves unused
  localparam logic [tcfw_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [tcfw_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int DRAIN_CYCLES   = tcfw_pkg::CELL_COUNT + 100;
  localparam int SQUEEZE_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_seen = 0;
  int          burst_left;

  tcfw_in_if  in_ch ();
  tcfw_out_if out_ch ();

  text_console_frame_writer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  tcfw_console_checker console_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // result count, used to place the long receiver hold-offs
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) results_seen++;
  end

  // receiver: rotating ready patterns plus two long hold-offs
  initial begin : receiver
    logic [7:0] pattern;
    int         phase_left;
    int         bit_idx;
    int         hold_left;
    int         squeezes;
    out_ch.ready = 1'b0;
    pattern      = '1;
    phase_left   = 0;
    bit_idx      = 0;
    hold_left    = 0;
    squeezes     = 0;
    forever begin
      @(negedge clk);
      if ((squeezes == 0 && results_seen >= 100) ||
          (squeezes == 1 && results_seen >= 700)) begin
        hold_left = SQUEEZE_CYCLES;
        squeezes++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        if (phase_left == 0) begin
          pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
          // never park the receiver for a whole phase
          if (pattern == 8'h00) pattern = 8'h01;
          phase_left = $urandom_range(16, 64);
        end
        out_ch.ready = pattern[bit_idx];
        bit_idx      = (bit_idx + 1) % 8;
        phase_left--;
      end
    end
  end

  // offer one item, starting and ending at a falling edge
  task automatic offer_item(
    input logic [tcfw_pkg::ACTION_W-1:0] act,
    input logic [tcfw_pkg::CHAR_W-1:0]   ch,
    input logic [7:0]                    color,
    input logic [tcfw_pkg::NUM_W-1:0]    num,
    input logic [tcfw_pkg::CADDR_W-1:0]  addr
  );
    // gap between bursts, with junk on the payload
    if (burst_left == 0) begin
      in_ch.valid        = 1'b0;
      in_ch.action       = tcfw_pkg::ACTION_W'($urandom);
      in_ch.char_code    = tcfw_pkg::CHAR_W'($urandom);
      in_ch.color        = 8'($urandom);
      in_ch.number       = tcfw_pkg::NUM_W'($urandom);
      in_ch.cell_address = tcfw_pkg::CADDR_W'($urandom);
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.action       = act;
    in_ch.char_code    = ch;
    in_ch.color        = color;
    in_ch.number       = num;
    in_ch.cell_address = addr;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned                   pick;
    logic [tcfw_pkg::ACTION_W-1:0] act;
    logic [tcfw_pkg::CHAR_W-1:0]   ch;
    logic [tcfw_pkg::NUM_W-1:0]    num;
    logic [tcfw_pkg::CADDR_W-1:0]  addr;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = '0;
    in_ch.char_code    = '0;
    in_ch.color        = '0;
    in_ch.number       = '0;
    in_ch.cell_address = '0;
    burst_left         = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reads of the fresh screen, in range and past the end
    offer_item(tcfw_pkg::ACT_READ, 8'h00, 8'h00, 16'h0000, 11'd0);
    offer_item(tcfw_pkg::ACT_READ, 8'h00, 8'h00, 16'h0000, 11'd1999);
    offer_item(tcfw_pkg::ACT_READ, 8'h00, 8'h00, 16'h0000, 11'd2000);
    offer_item(tcfw_pkg::ACT_READ, 8'hFF, 8'hFF, 16'hFFFF, 11'h7FF);
    // character extremes and a newline
    offer_item(tcfw_pkg::ACT_PUT_CHAR, 8'h41, 8'h1E, 16'h0000, 11'd0);
    offer_item(tcfw_pkg::ACT_PUT_CHAR, 8'h00, 8'h00, 16'h0000, 11'd0);
    offer_item(tcfw_pkg::ACT_PUT_CHAR, 8'hFF, 8'hFF, 16'hFFFF, 11'h7FF);
    offer_item(tcfw_pkg::ACT_PUT_CHAR, tcfw_pkg::NEWLINE_CHAR, 8'hAA, 16'h0000, 11'd0);
    // decimal: zero, largest, single digit, trailing zero
    offer_item(tcfw_pkg::ACT_PUT_DEC, 8'h00, 8'h0F, 16'd0, 11'd0);
    offer_item(tcfw_pkg::ACT_PUT_DEC, 8'h00, 8'hF0, 16'hFFFF, 11'd0);
    offer_item(tcfw_pkg::ACT_PUT_DEC, 8'h00, 8'h33, 16'd9, 11'd0);
    offer_item(tcfw_pkg::ACT_PUT_DEC, 8'h00, 8'h55, 16'd10, 11'd0);
    offer_item(tcfw_pkg::ACT_DELETE, 8'h00, 8'h00, 16'h0000, 11'd0);
    offer_item(tcfw_pkg::ACT_READ, 8'h00, 8'h00, 16'h0000, 11'd80);
    // unused action codes
    offer_item(ACT_SPARE_LO, 8'hFF, 8'hFF, 16'hFFFF, 11'h7FF);
    offer_item(ACT_SPARE_HI, 8'h41, 8'h12, 16'h1234, 11'd5);
    // whole-screen actions
    offer_item(tcfw_pkg::ACT_PAINT, 8'h00, 8'hFF, 16'h0000, 11'd0);
    offer_item(tcfw_pkg::ACT_READ, 8'h00, 8'h00, 16'h0000, 11'd1999);
    offer_item(tcfw_pkg::ACT_PAINT, 8'hFF, 8'h00, 16'h0000, 11'd0);
    offer_item(tcfw_pkg::ACT_CLEAR, 8'h00, 8'h00, 16'h0000, 11'd0);
    // delete with the cursor already home
    offer_item(tcfw_pkg::ACT_DELETE, 8'h00, 8'h00, 16'h0000, 11'd0);
    offer_item(tcfw_pkg::ACT_DELETE, 8'hFF, 8'hFF, 16'hFFFF, 11'h7FF);
    offer_item(tcfw_pkg::ACT_PUT_CHAR, tcfw_pkg::NEWLINE_CHAR, 8'h00, 16'h0000, 11'd0);

    // weighted random mix: mostly text, some numbers, rare full-screen actions
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      ch   = tcfw_pkg::CHAR_W'($urandom);
      num  = tcfw_pkg::NUM_W'($urandom);
      addr = tcfw_pkg::CADDR_W'($urandom);
      if (pick < 45) begin
        act = tcfw_pkg::ACT_PUT_CHAR;
        if ($urandom_range(0, 7) == 0) ch = tcfw_pkg::NEWLINE_CHAR;
      end else if (pick < 65) begin
        act = tcfw_pkg::ACT_PUT_DEC;
        case ($urandom_range(0, 3))
          0: num = tcfw_pkg::NUM_W'($urandom_range(0, 9));
          1: num = tcfw_pkg::NUM_W'($urandom_range(0, 999));
          2: num = tcfw_pkg::NUM_W'($urandom_range(10000, 65535));
          default: ;
        endcase
      end else if (pick < 76) begin
        act = tcfw_pkg::ACT_DELETE;
      end else if (pick < 95) begin
        act = tcfw_pkg::ACT_READ;
        addr = ($urandom_range(0, 7) == 0) ?
               tcfw_pkg::CADDR_W'($urandom_range(tcfw_pkg::CELL_COUNT, 2047)) :
               tcfw_pkg::CADDR_W'($urandom_range(0, tcfw_pkg::CELL_COUNT - 1));
      end else if (pick < 96) begin
        act = tcfw_pkg::ACT_CLEAR;
      end else if (pick < 97) begin
        act = tcfw_pkg::ACT_PAINT;
      end else begin
        act = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end
      offer_item(act, ch, 8'($urandom), num, addr);
    end
    in_ch.valid = 1'b0;

    // let the last results drain, then watch for strays
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
